FILE: src/bda_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Constants and control/status types shared by the converter's modules.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IN_W       = 32;
  localparam int unsigned BCD_W      = 4 * MAX_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned DIG_CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } bda_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic skip;
    logic emit;
  } bda_cmd_t;

  typedef struct packed {
    logic in_neg;
    logic conv_done;
    logic top_zero;
    logic one_left;
    logic neg;
    logic out_free;
  } bda_status_t;

endpackage

FILE: src/bda_ctrl.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII controller
// One-hot state machine sequencing load, conversion, zero skip and emission.
// ----------------------------------------------------------------------------
module bda_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bda_pkg::bda_status_t status_i,
  output bda_pkg::bda_cmd_t   cmd_o
);

  bda_pkg::bda_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_neg ? bda_pkg::ST_EMIT : bda_pkg::ST_CONV;
        end
      end
      bda_pkg::ST_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.conv_done) begin
          state_d = bda_pkg::ST_SKIP;
        end
      end
      bda_pkg::ST_SKIP: begin
        if (status_i.top_zero && !status_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = bda_pkg::ST_EMIT;
        end
      end
      bda_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.neg || status_i.one_left) begin
            state_d = bda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bda_dp.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII datapath
// Shift-and-add-3 converter, digit shifter and output word register.
// ----------------------------------------------------------------------------
module bda_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [bda_pkg::IN_W-1:0]              in_data_i,
  input  bda_pkg::bda_cmd_t                     cmd_i,
  output bda_pkg::bda_status_t                  status_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [bda_pkg::CHAR_W-1:0]            out_char_o,
  output logic                                  out_last_o,
  output logic                                  out_nodig_o
);

  logic [bda_pkg::VALUE_BITS-1:0] shift_q, shift_d;
  logic [bda_pkg::BCD_W-1:0]      bcd_q, bcd_d, bcd_adj;
  logic [bda_pkg::BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [bda_pkg::DIG_CNT_W-1:0]  dig_cnt_q, dig_cnt_d;
  logic                           neg_q, neg_d;
  logic                           out_valid_q, out_valid_d;
  logic [bda_pkg::CHAR_W-1:0]     out_char_q, out_char_d;
  logic                           out_last_q, out_last_d;
  logic                           out_nodig_q, out_nodig_d;
  logic [3:0]                     top_nib;

  assign top_nib = bcd_q[bda_pkg::BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < bda_pkg::MAX_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    shift_d     = shift_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_nodig_d = out_nodig_q;
    if (cmd_i.load) begin
      shift_d   = in_data_i[bda_pkg::VALUE_BITS-1:0];
      bcd_d     = '0;
      bit_cnt_d = '0;
      dig_cnt_d = bda_pkg::DIG_CNT_W'(bda_pkg::MAX_DIGITS);
      neg_d     = in_data_i[bda_pkg::IN_W-1];
    end
    if (cmd_i.step) begin
      shift_d   = {shift_q[bda_pkg::VALUE_BITS-2:0], 1'b0};
      bcd_d     = {bcd_adj[bda_pkg::BCD_W-2:0], shift_q[bda_pkg::VALUE_BITS-1]};
      bit_cnt_d = bit_cnt_q + 1'b1;
    end
    if (cmd_i.skip || cmd_i.emit) begin
      bcd_d     = {bcd_q[bda_pkg::BCD_W-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = neg_q ? '0 : bda_pkg::ASCII_ZERO + {2'b00, top_nib};
      out_last_d  = neg_q | status_o.one_left;
      out_nodig_d = neg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q     <= shift_d;
    bcd_q       <= bcd_d;
    out_char_q  <= out_char_d;
    out_last_q  <= out_last_d;
    out_nodig_q <= out_nodig_d;
  end

  assign status_o.in_neg    = in_data_i[bda_pkg::IN_W-1];
  assign status_o.conv_done = (bit_cnt_q == bda_pkg::BIT_CNT_W'(bda_pkg::VALUE_BITS - 1));
  assign status_o.top_zero  = (top_nib == 4'd0);
  assign status_o.one_left  = (dig_cnt_q == bda_pkg::DIG_CNT_W'(1));
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = ~out_valid_q | out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_nodig_o = out_nodig_q;

endmodule

FILE: src/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit
// Converts a signed 32-bit integer into its ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each accepted word is a signed integer. A non-negative value produces its
// decimal digits as ASCII words, most significant first, without leading
// zeros, with tlast on the final digit; zero gives a single '0'. A negative
// value produces one word with tuser set and tdata zero. Only the low 31 bits
// are converted. A non-negative item is accepted, runs the shift-and-add-3
// conversion over those 31 bits, shifts out each suppressed leading zero,
// passes a state that starts emission and then emits its digits, where the
// suppressed zeros and the digits always add up to ten. A negative item goes
// from accept straight to emission. A stalled sink adds its wait to every
// emitted word. A new word is accepted once the last digit of the previous
// one sits in the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] number_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [5:0] digit_char, [7:6] zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] no_digits
);

  bda_pkg::bda_cmd_t              cmd;
  bda_pkg::bda_status_t           status;
  logic [bda_pkg::CHAR_W-1:0]     out_char;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o),
    .out_nodig_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(bda_pkg::OUT_DATA_W - bda_pkg::CHAR_W){1'b0}}, out_char};

endmodule
